>>> src/ulg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ulg_pkg;

    // Field widths
    localparam int unsigned ECHO_W  = 16;
    localparam int unsigned LEVEL_W = 14;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 32;

    // Divide-by-constant unit: dividend width, divisor width, coefficient width
    localparam int unsigned DIV_W   = 24;
    localparam int unsigned DIV_D_W = 11;
    localparam int unsigned COEF_W  = 8;

    // Segment edges of the level formula
    localparam logic [ECHO_W-1:0] EDGE_NEAR = 16'd460;
    localparam logic [ECHO_W-1:0] EDGE_FAR  = 16'd1260;

    // Near segment: level = 182 - e*182/1620
    localparam logic [COEF_W-1:0]  NEAR_K = 8'd182;
    localparam logic [DIV_D_W-1:0] NEAR_D = 11'd1620;
    // Far segment: level = 162 - e*162/1495
    localparam logic [COEF_W-1:0]  FAR_K  = 8'd162;
    localparam logic [DIV_D_W-1:0] FAR_D  = 11'd1495;
    // Middle segment: level = 190 - e*190/1455
    localparam logic [COEF_W-1:0]  MID_K  = 8'd190;
    localparam logic [DIV_D_W-1:0] MID_D  = 11'd1455;

    // Reciprocals floor((2^DIV_W - 1) / d)
    localparam logic [DIV_W-1:0] NEAR_M = DIV_W'(((1 << DIV_W) - 1) / 1620);
    localparam logic [DIV_W-1:0] FAR_M  = DIV_W'(((1 << DIV_W) - 1) / 1495);
    localparam logic [DIV_W-1:0] MID_M  = DIV_W'(((1 << DIV_W) - 1) / 1455);

    // Register reset values
    localparam logic [CFG_W-1:0] FULL_LEVEL_RST   = 8'd164;
    localparam logic [CFG_W-1:0] PUMP_RESTART_RST = 8'd5;

    // Register indexes
    typedef enum logic [0:0] {
        REG_FULL_LEVEL   = 1'b0,
        REG_PUMP_RESTART = 1'b1
    } ulg_reg_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_NORMAL = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2
    } ulg_status_t;

    // Display symbol codes beyond the decimal digits
    localparam logic [DIGIT_W-1:0] SYM_DASH = 4'd10;
    localparam logic [DIGIT_W-1:0] SYM_F    = 4'd11;
    localparam logic [DIGIT_W-1:0] SYM_U    = 4'd12;
    localparam logic [DIGIT_W-1:0] SYM_L    = 4'd13;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic recip;
        logic back;
        logic corr;
        logic avg_phase;
        logic fill;
        logic accum;
        logic avg_load;
        logic publish;
    } ulg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_last;
    } ulg_stat_t;

endpackage

`default_nettype wire

>>> src/ultrasonic_level_gauge.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// s_        s_tvalid/s_tready    s_tdata[15:0]  echo_count
// m_        m_tvalid/m_tready    m_tdata[28:0]  level_avg, status, digits, pump_on
// cfg_      cfg_wr_en            cfg_index, cfg_wdata[7:0]
//
// The result beat is registered once the average is divided; the next input beat is taken
// only after the result is published and the block is back in idle. The first item after
// reset waits while the ring is filled, one entry a cycle.
// The shared reciprocal-multiply divider runs twice per item (level, then average).
// Reset is synchronous, active low; the ring contents are not cleared.
// A result that is not taken holds the block in its last step; s_tready stays low.

module ultrasonic_level_gauge #(
    parameter int AVG_DEPTH = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // echo_count[15:0]
    input  wire logic [ulg_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // level_avg[13:0], status[15:14], digit_hundreds[19:16], digit_tens[23:20],
    // digit_units[27:24], pump_on[28], zero[31:29]
    output logic [ulg_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                      cfg_wr_en,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [ulg_pkg::CFG_W-1:0] cfg_wdata
);
    import ulg_pkg::*;

    ulg_cmd_t           cmd;
    ulg_stat_t          st;
    logic [LEVEL_W-1:0] level_avg;
    logic [STAT_W-1:0]  status;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_units;
    logic               pump_on;

    ulg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ulg_datapath #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .echo_count     (s_tdata[ECHO_W-1:0]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .st             (st),
        .level_avg      (level_avg),
        .status         (status),
        .digit_hundreds (digit_hundreds),
        .digit_tens     (digit_tens),
        .digit_units    (digit_units),
        .pump_on        (pump_on)
    );

    // Pack the result beat
    assign m_tdata = {3'b000, pump_on, digit_units, digit_tens, digit_hundreds,
                      status, level_avg};

endmodule

`default_nettype wire

>>> src/ulg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ulg_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire ulg_pkg::ulg_stat_t st,
    output ulg_pkg::ulg_cmd_t      cmd
);
    import ulg_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL   = 10'b00_0000_0010,
        ST_RECIP = 10'b00_0000_0100,
        ST_BACK  = 10'b00_0000_1000,
        ST_CORR  = 10'b00_0001_0000,
        ST_FILL  = 10'b00_0010_0000,
        ST_ACCUM = 10'b00_0100_0000,
        ST_AVGLD = 10'b00_1000_0000,
        ST_PUB   = 10'b01_0000_0000,
        ST_SPARE = 10'b10_0000_0000
    } ulg_state_t;

    ulg_state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic       filled_reg, filled_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // Sequence one item through level, ring update and average
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        filled_next = filled_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK: begin
                cmd.back   = 1'b1;
                state_next = ST_CORR;
            end
            ST_CORR: begin
                cmd.corr      = 1'b1;
                cmd.avg_phase = phase_reg;
                if (phase_reg) begin
                    state_next = ST_PUB;
                end else if (filled_reg) begin
                    state_next = ST_ACCUM;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (st.fill_last) begin
                    filled_next = 1'b1;
                    state_next  = ST_AVGLD;
                end
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = ST_AVGLD;
            end
            ST_AVGLD: begin
                cmd.avg_load = 1'b1;
                phase_next   = 1'b1;
                state_next   = ST_RECIP;
            end
            ST_PUB: begin
                // Hold until the output register is free or being drained
                if (!m_tvalid_reg || m_tready) begin
                    cmd.publish = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                phase_next = 1'b0;
            end
        endcase
    end

    // Output beat valid
    always_comb begin
        if (cmd.publish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 1'b0;
            filled_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            filled_reg   <= filled_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

>>> src/ulg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ulg_datapath #(
    parameter int AVG_DEPTH = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [ulg_pkg::ECHO_W-1:0]        echo_count,
    input  wire logic                              cfg_wr_en,
    input  wire logic [0:0]                        cfg_index,
    input  wire logic [ulg_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire ulg_pkg::ulg_cmd_t                 cmd,
    output ulg_pkg::ulg_stat_t                     st,
    output logic [ulg_pkg::LEVEL_W-1:0]            level_avg,
    output logic [ulg_pkg::STAT_W-1:0]             status,
    output logic [ulg_pkg::DIGIT_W-1:0]            digit_hundreds,
    output logic [ulg_pkg::DIGIT_W-1:0]            digit_tens,
    output logic [ulg_pkg::DIGIT_W-1:0]            digit_units,
    output logic                                   pump_on
);
    import ulg_pkg::*;

    localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W = LEVEL_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(AVG_DEPTH - 1);
    localparam logic [IDX_W-1:0]   SLOT_AFTER = IDX_W'(1 % AVG_DEPTH);
    localparam logic [DIV_D_W-1:0] AVG_D      = DIV_D_W'(AVG_DEPTH);
    localparam logic [DIV_W-1:0]   AVG_M      = DIV_W'(((1 << DIV_W) - 1) / AVG_DEPTH);

    // Configuration registers
    logic [CFG_W-1:0] full_level_reg;
    logic [CFG_W-1:0] restart_reg;

    // Level and divide unit
    logic [ECHO_W-1:0]  e_reg;
    logic [COEF_W-1:0]  k_reg;
    logic [COEF_W-1:0]  base_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_W-1:0]   m_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   qe_reg;
    logic [DIV_W-1:0]   back_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] avg_reg;
    logic               neg_reg;

    // Averaging ring
    logic signed [LEVEL_W-1:0] ring [AVG_DEPTH];
    logic signed [LEVEL_W-1:0] old_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic [IDX_W-1:0]          fill_reg;
    logic                      pump_stopped_reg;

    // Result register
    logic [LEVEL_W-1:0] out_level_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [DIGIT_W-1:0] out_d100_reg;
    logic [DIGIT_W-1:0] out_d10_reg;
    logic [DIGIT_W-1:0] out_d1_reg;
    logic               out_pump_reg;

    // Combinational terms
    logic [COEF_W-1:0]  sel_k;
    logic [DIV_D_W-1:0] sel_d;
    logic [DIV_W-1:0]   sel_m;
    logic [2*DIV_W-1:0] recip_prod;
    logic [DIV_W+DIV_D_W-1:0] back_prod;
    logic [DIV_W-1:0]   rem;
    logic [DIV_W-1:0]   q;
    logic [LEVEL_W:0]   level_diff;
    logic [IDX_W-1:0]   ring_addr;
    logic               ring_we;
    logic signed [SUM_W-1:0] level_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W:0]     sum_mag;
    logic               is_empty;
    logic               is_full;
    logic [CFG_W-1:0]   v;
    logic [1:0]         hund;
    logic [CFG_W-1:0]   rest;
    logic [14:0]        tens_prod;
    logic [DIGIT_W-1:0] tens;
    logic [CFG_W-1:0]   units_wide;
    logic [STAT_W-1:0]  stat_sel;
    logic [DIGIT_W-1:0] d100_sel;
    logic [DIGIT_W-1:0] d10_sel;
    logic [DIGIT_W-1:0] d1_sel;
    logic               stopped_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_level_reg <= FULL_LEVEL_RST;
            restart_reg    <= PUMP_RESTART_RST;
        end else if (cfg_wr_en) begin
            case (ulg_reg_t'(cfg_index))
                REG_FULL_LEVEL:   full_level_reg <= cfg_wdata;
                REG_PUMP_RESTART: restart_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pick the formula segment from the incoming width
    always_comb begin
        if (echo_count <= EDGE_NEAR) begin
            sel_k = NEAR_K;
            sel_d = NEAR_D;
            sel_m = NEAR_M;
        end else if (echo_count >= EDGE_FAR) begin
            sel_k = FAR_K;
            sel_d = FAR_D;
            sel_m = FAR_M;
        end else begin
            sel_k = MID_K;
            sel_d = MID_D;
            sel_m = MID_M;
        end
    end

    // Reciprocal quotient estimate, back-multiply and one-step correction
    assign recip_prod = num_reg * m_reg;
    assign back_prod  = qe_reg * d_reg;
    assign rem        = num_reg - back_reg;
    assign q          = qe_reg + DIV_W'(rem >= DIV_W'(d_reg));
    assign level_diff = {{(LEVEL_W + 1 - COEF_W){1'b0}}, base_reg} - {1'b0, q[LEVEL_W-1:0]};

    // Ring write port and running sum terms
    assign ring_addr = cmd.fill ? fill_reg : slot_reg;
    assign ring_we   = cmd.fill | cmd.accum;
    assign level_ext = SUM_W'(level_reg);
    assign old_ext   = SUM_W'(old_reg);
    assign sum_wide  = {sum_reg[SUM_W-1], sum_reg};
    assign sum_mag   = sum_reg[SUM_W-1] ? ((SUM_W + 1)'(0) - sum_wide) : sum_wide;

    assign st.fill_last = (fill_reg == IDX_LAST);

    // Ring memory: registered read of the slot about to be replaced
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[ring_addr] <= level_reg;
        end
        if (cmd.capture) begin
            old_reg <= ring[slot_reg];
        end
    end

    // Datapath payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            e_reg    <= echo_count;
            k_reg    <= sel_k;
            base_reg <= sel_k;
            d_reg    <= sel_d;
            m_reg    <= sel_m;
        end
        if (cmd.mul) begin
            num_reg <= DIV_W'(e_reg * k_reg);
        end
        if (cmd.recip) begin
            qe_reg <= recip_prod[2*DIV_W-1:DIV_W];
        end
        if (cmd.back) begin
            back_reg <= back_prod[DIV_W-1:0];
        end
        if (cmd.corr) begin
            if (cmd.avg_phase) begin
                avg_reg <= neg_reg ? (LEVEL_W'(0) - q[LEVEL_W-1:0]) : q[LEVEL_W-1:0];
            end else begin
                level_reg <= level_diff[LEVEL_W-1:0];
            end
        end
        if (cmd.fill) begin
            sum_reg <= ((fill_reg == '0) ? SUM_W'(0) : sum_reg) + level_ext;
        end
        if (cmd.accum) begin
            sum_reg <= sum_reg - old_ext + level_ext;
        end
        if (cmd.avg_load) begin
            neg_reg <= sum_reg[SUM_W-1];
            num_reg <= DIV_W'(sum_mag);
            d_reg   <= AVG_D;
            m_reg   <= AVG_M;
        end
    end

    // Classify the average and split it into decimal digits
    assign is_empty  = avg_reg[LEVEL_W-1] || (avg_reg == '0);
    assign is_full   = !is_empty && (avg_reg > LEVEL_W'(full_level_reg));
    assign v         = avg_reg[CFG_W-1:0];
    assign hund      = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    assign rest      = v - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    assign tens_prod = rest[6:0] * 8'd205;
    assign tens      = tens_prod[14:11];
    assign units_wide = rest - (CFG_W'(tens) * 8'd10);

    always_comb begin
        stopped_next = pump_stopped_reg;
        if (is_empty) begin
            stat_sel     = STAT_EMPTY;
            d100_sel     = SYM_DASH;
            d10_sel      = SYM_DASH;
            d1_sel       = SYM_DASH;
            stopped_next = 1'b1;
        end else if (is_full) begin
            stat_sel = STAT_FULL;
            d100_sel = SYM_F;
            d10_sel  = SYM_U;
            d1_sel   = SYM_L;
        end else begin
            stat_sel = STAT_NORMAL;
            d100_sel = DIGIT_W'(hund);
            d10_sel  = tens;
            d1_sel   = units_wide[DIGIT_W-1:0];
            if (v >= restart_reg) begin
                stopped_next = 1'b0;
            end
        end
    end

    // Slot, fill index and pump state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg         <= '0;
            fill_reg         <= '0;
            pump_stopped_reg <= 1'b0;
        end else begin
            if (cmd.fill) begin
                fill_reg <= st.fill_last ? '0 : fill_reg + 1'b1;
                if (st.fill_last) begin
                    slot_reg <= SLOT_AFTER;
                end
            end
            if (cmd.accum) begin
                slot_reg <= (slot_reg == IDX_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.publish) begin
                pump_stopped_reg <= stopped_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_level_reg  <= avg_reg;
            out_status_reg <= stat_sel;
            out_d100_reg   <= d100_sel;
            out_d10_reg    <= d10_sel;
            out_d1_reg     <= d1_sel;
            out_pump_reg   <= !stopped_next;
        end
    end

    assign level_avg      = out_level_reg;
    assign status         = out_status_reg;
    assign digit_hundreds = out_d100_reg;
    assign digit_tens     = out_d10_reg;
    assign digit_units    = out_d1_reg;
    assign pump_on        = out_pump_reg;

endmodule

`default_nettype wire

>>> src/ulg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ulg_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [ulg_pkg::M_DATA_W-1:0] m_tdata
);
    import ulg_pkg::*;

    // One item at a time: no second input beat right after an accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

    // Empty shows dashes and a stopped pump
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] == STAT_EMPTY) |->
        (m_tdata[19:16] == SYM_DASH && m_tdata[23:20] == SYM_DASH &&
         m_tdata[27:24] == SYM_DASH && !m_tdata[28] &&
         (m_tdata[13] || m_tdata[13:0] == 14'd0)))
    else $error("empty result inconsistent");

    // Full shows F U L over a positive average
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] == STAT_FULL) |->
        (m_tdata[19:16] == SYM_F && m_tdata[23:20] == SYM_U &&
         m_tdata[27:24] == SYM_L && !m_tdata[13] && m_tdata[13:0] != 14'd0))
    else $error("full result inconsistent");

    // Normal shows decimal digits of a positive average below 256
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] == STAT_NORMAL) |->
        (m_tdata[13:8] == 6'd0 && m_tdata[7:0] != 8'd0 &&
         m_tdata[19:16] <= 4'd2 && m_tdata[23:20] <= 4'd9 && m_tdata[27:24] <= 4'd9))
    else $error("normal result inconsistent");

endmodule

bind ultrasonic_level_gauge ulg_checker u_checker (.*);

`default_nettype wire
